// ----- rtl/dhcpc_pkg.sv -----
package dhcpc_pkg;

   localparam int unsigned RSP_FIFO_DEPTH = 4;

   localparam logic [31:0] RESET_DEFAULT_MASK  = 32'hFFFF_FF00;
   localparam logic [31:0] RESET_DEFAULT_LEASE = 32'd3600;
   localparam logic [7:0]  RESET_INITIAL_WAIT  = 8'd2;
   localparam logic [7:0]  RESET_MAX_WAIT      = 8'd32;
   localparam logic [7:0]  RESET_REQ_INTERVAL  = 8'd4;
   localparam logic [7:0]  RESET_REQ_TRIES     = 8'd3;
   localparam logic [7:0]  COUNT_MAX           = 8'hFF;

   typedef enum logic [2:0] {
      EV_TICK    = 3'd0,
      EV_LINK_UP = 3'd1,
      EV_OFFER   = 3'd2,
      EV_ACK     = 3'd3,
      EV_NAK     = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      PH_NO_LINK  = 2'd0,
      PH_DISCOVER = 2'd1,
      PH_REQUEST  = 2'd2,
      PH_BOUND    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE       = 2'd0,
      ACT_DISCOVER   = 2'd1,
      ACT_REQ_SELECT = 2'd2,
      ACT_REQ_RENEW  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CSR_DEFAULT_MASK  = 3'd0,
      CSR_DEFAULT_LEASE = 3'd1,
      CSR_INITIAL_WAIT  = 3'd2,
      CSR_MAX_WAIT      = 3'd3,
      CSR_REQ_INTERVAL  = 3'd4,
      CSR_REQ_TRIES     = 3'd5
   } csr_type;

   typedef struct packed {
      action_type  action;
      logic        new_transaction;
      logic [31:0] request_address;
      logic [31:0] request_server;
      phase_type   client_phase;
      logic [31:0] bound_address;
      logic [31:0] subnet_mask;
      logic [31:0] router_address;
      logic [31:0] dns_address;
      logic [31:0] time_server;
      logic        last;
   } rsp_type;

   // renewal marks every 10 s below one minute
   function automatic logic renew_mark(input logic [31:0] left);
      renew_mark = (left == 32'd10) || (left == 32'd20) || (left == 32'd30) ||
                   (left == 32'd40) || (left == 32'd50);
   endfunction

endpackage

// ----- rtl/dhcpc_rsp_fifo.sv -----
module dhcpc_rsp_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  logic                push_two,
   input  dhcpc_pkg::rsp_type  push_data0,
   input  dhcpc_pkg::rsp_type  push_data1,
   output logic                room,
   input  logic                pop,
   output logic                head_valid,
   output dhcpc_pkg::rsp_type  head_data
);
   import dhcpc_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rsp_type          mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_ptr_nx  = ptr_inc(wr_ptr_ff);
   assign room       = (count_ff <= CW'(DEPTH - 2));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = push_two ? ptr_inc(wr_ptr_nx) : wr_ptr_nx;
         count_in  = count_in + (push_two ? CW'(2) : CW'(1));
      end
      if (pop) begin
         rd_ptr_in = ptr_inc(rd_ptr_ff);
         count_in  = count_in - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (push_en && (wr_ptr_ff == PW'(i))) begin
            mem_ff[i] <= push_data0;
         end
         if (push_en && push_two && (wr_ptr_nx == PW'(i))) begin
            mem_ff[i] <= push_data1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("response fifo overfilled");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("response fifo popped while empty");
   assert property (@(posedge clock) disable iff (reset)
                    push_en |-> room)
      else $error("response fifo written without room for two words");

endmodule

// ----- rtl/dhcp_client_lease_machine_core.sv -----
// DHCP client lease sequencer.
// Request channel (req_*): one event word per handshake: a one-second tick,
// link up, or a parsed OFFER, ACK or NAK. A word is taken at a clock edge
// with req_valid high and req_stall low.
// Response channel (rsp_*): each event word yields one or two words; rsp_last
// marks the final one. A bound-phase tick that both renews and hits lease
// expiry yields two words (renew request, then a fresh discover).
// Path: the event is registered on acceptance, stepped once the response queue
// has room, and its response words are presented from the queue head.
// Throughput: one event word per cycle; the limit is the response queue,
// which must hold room for two words before the registered event is stepped.
// When the receiver stalls, responses collect in the queue (RSP_DEPTH words)
// and req_stall rises while an event is held and fewer than two entries are free.
// Configuration (csr_*): a write at any edge with csr_write high; the user must
// change registers only while no event is in flight; the block does not enforce this.
// Reset (synchronous, active high) empties the queue and the event register,
// puts the client in the no-link phase and loads register defaults.
module dhcp_client_lease_machine_core #(
   parameter int unsigned RSP_DEPTH = dhcpc_pkg::RSP_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_your_address,
   input  logic [31:0] req_server_option,
   input  logic [31:0] req_next_server,
   input  logic [31:0] req_mask_option,
   input  logic [31:0] req_router_option,
   input  logic [31:0] req_dns_option,
   input  logic [31:0] req_time_option,
   input  logic [31:0] req_lease_option,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic        rsp_new_transaction,
   output logic [31:0] rsp_request_address,
   output logic [31:0] rsp_request_server,
   output logic [1:0]  rsp_client_phase,
   output logic [31:0] rsp_bound_address,
   output logic [31:0] rsp_subnet_mask,
   output logic [31:0] rsp_router_address,
   output logic [31:0] rsp_dns_address,
   output logic [31:0] rsp_time_server,
   output logic        rsp_last
);
   import dhcpc_pkg::*;

   // configuration
   logic [31:0] def_mask_ff, def_lease_ff;
   logic [7:0]  init_wait_ff, max_wait_ff, req_interval_ff, req_tries_ff;

   // registered event word
   logic        ev_valid_ff;
   logic [2:0]  ev_type_ff;
   logic [31:0] ev_yiaddr_ff, ev_server_ff, ev_mask_ff, ev_router_ff;
   logic [31:0] ev_dns_ff, ev_time_ff, ev_lease_ff;

   // client state
   phase_type   phase_ff, phase_in;
   logic        link_ff, link_in;
   logic [31:0] seconds_ff, seconds_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [7:0]  backoff_ff, backoff_in;
   logic [7:0]  attempts_ff, attempts_in;
   logic [31:0] lease_total_ff, lease_total_in;
   logic [31:0] lease_left_ff, lease_left_in;
   logic [31:0] offered_ff, offered_in;
   logic [31:0] server_ff, server_in;
   logic [31:0] own_ff, own_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] router_ff, router_in;
   logic [31:0] dns_ff, dns_in;
   logic [31:0] ntp_ff, ntp_in;

   logic        step_go;
   logic        q_room;
   logic        q_pop;
   logic        do_restart;
   logic        do_renew;
   logic        do_emit;
   action_type  emit_action;
   logic [31:0] emit_addr, emit_server;
   logic [7:0]  attempts_bump;
   logic [8:0]  backoff_dbl;
   logic [31:0] lease_dec;
   rsp_type     word0, word1, head;

   assign step_go   = ev_valid_ff && q_room;
   assign req_stall = ev_valid_ff && !q_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         def_mask_ff     <= RESET_DEFAULT_MASK;
         def_lease_ff    <= RESET_DEFAULT_LEASE;
         init_wait_ff    <= RESET_INITIAL_WAIT;
         max_wait_ff     <= RESET_MAX_WAIT;
         req_interval_ff <= RESET_REQ_INTERVAL;
         req_tries_ff    <= RESET_REQ_TRIES;
      end else if (csr_write) begin
         case (csr_type'(csr_index))
            CSR_DEFAULT_MASK:  def_mask_ff     <= csr_data;
            CSR_DEFAULT_LEASE: def_lease_ff    <= csr_data;
            CSR_INITIAL_WAIT:  init_wait_ff    <= csr_data[7:0];
            CSR_MAX_WAIT:      max_wait_ff     <= csr_data[7:0];
            CSR_REQ_INTERVAL:  req_interval_ff <= csr_data[7:0];
            CSR_REQ_TRIES:     req_tries_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         ev_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         ev_type_ff   <= req_type;
         ev_yiaddr_ff <= req_your_address;
         ev_server_ff <= (req_server_option != '0) ? req_server_option : req_next_server;
         ev_mask_ff   <= req_mask_option;
         ev_router_ff <= req_router_option;
         ev_dns_ff    <= req_dns_option;
         ev_time_ff   <= req_time_option;
         ev_lease_ff  <= req_lease_option;
      end
   end

   assign attempts_bump = (attempts_ff == COUNT_MAX) ? attempts_ff : attempts_ff + 8'd1;
   assign backoff_dbl   = {backoff_ff, 1'b0};
   assign lease_dec     = (lease_left_ff != '0) ? lease_left_ff - 32'd1 : lease_left_ff;

   always_comb begin
      phase_in       = phase_ff;
      link_in        = link_ff;
      seconds_in     = seconds_ff;
      deadline_in    = deadline_ff;
      backoff_in     = backoff_ff;
      attempts_in    = attempts_ff;
      lease_total_in = lease_total_ff;
      lease_left_in  = lease_left_ff;
      offered_in     = offered_ff;
      server_in      = server_ff;
      own_in         = own_ff;
      mask_in        = mask_ff;
      router_in      = router_ff;
      dns_in         = dns_ff;
      ntp_in         = ntp_ff;
      do_restart     = 1'b0;
      do_renew       = 1'b0;
      do_emit        = 1'b0;
      emit_action    = ACT_NONE;
      emit_addr      = '0;
      emit_server    = '0;

      case (event_type'(ev_type_ff))
         EV_TICK: begin
            seconds_in = seconds_ff + 32'd1;
            if (link_ff) begin
               if (phase_ff == PH_DISCOVER && seconds_in >= deadline_ff) begin
                  attempts_in = attempts_bump;
                  if (backoff_ff < max_wait_ff) begin
                     backoff_in = backoff_dbl[8] ? COUNT_MAX : backoff_dbl[7:0];
                  end
                  deadline_in = seconds_in + {24'd0, backoff_in};
                  do_emit     = 1'b1;
                  emit_action = ACT_DISCOVER;
               end else if (phase_ff == PH_REQUEST && seconds_in >= deadline_ff) begin
                  attempts_in = attempts_bump;
                  if (attempts_bump > req_tries_ff) begin
                     do_restart = 1'b1;
                  end else begin
                     deadline_in = seconds_in + {24'd0, req_interval_ff};
                     do_emit     = 1'b1;
                     emit_action = ACT_REQ_SELECT;
                     emit_addr   = offered_ff;
                     emit_server = server_ff;
                  end
               end else if (phase_ff == PH_BOUND) begin
                  lease_left_in = lease_dec;
                  do_renew      = (lease_dec == {1'b0, lease_total_ff[31:1]}) ||
                                  renew_mark(lease_dec);
                  do_restart    = (lease_dec == '0);
               end
            end
         end
         EV_LINK_UP: begin
            link_in    = 1'b1;
            do_restart = 1'b1;
         end
         EV_OFFER: begin
            if (phase_ff == PH_DISCOVER) begin
               offered_in  = ev_yiaddr_ff;
               server_in   = ev_server_ff;
               phase_in    = PH_REQUEST;
               attempts_in = 8'd1;
               deadline_in = seconds_ff + {24'd0, req_interval_ff};
               do_emit     = 1'b1;
               emit_action = ACT_REQ_SELECT;
               emit_addr   = ev_yiaddr_ff;
               emit_server = ev_server_ff;
            end
         end
         EV_ACK: begin
            if (phase_ff == PH_REQUEST || phase_ff == PH_BOUND) begin
               own_in         = ev_yiaddr_ff;
               mask_in        = (ev_mask_ff != '0) ? ev_mask_ff : def_mask_ff;
               router_in      = ev_router_ff;
               dns_in         = ev_dns_ff;
               ntp_in         = ev_time_ff;
               lease_total_in = (ev_lease_ff != '0) ? ev_lease_ff : def_lease_ff;
               lease_left_in  = lease_total_in;
               phase_in       = PH_BOUND;
            end
         end
         EV_NAK: begin
            do_restart = link_ff;
         end
         default: ;
      endcase

      if (do_restart) begin
         phase_in    = PH_DISCOVER;
         own_in      = '0;
         backoff_in  = init_wait_ff;
         attempts_in = 8'd1;
         deadline_in = seconds_in + {24'd0, init_wait_ff};
      end
   end

   // word0: renew (pre-restart status), else restart/emit/quiet word
   always_comb begin
      word1.action          = ACT_DISCOVER;
      word1.new_transaction = 1'b1;
      word1.request_address = '0;
      word1.request_server  = '0;
      word1.client_phase    = phase_in;
      word1.bound_address   = own_in;
      word1.subnet_mask     = mask_in;
      word1.router_address  = router_in;
      word1.dns_address     = dns_in;
      word1.time_server     = ntp_in;
      word1.last            = 1'b1;

      word0 = word1;
      if (do_renew) begin
         word0.action          = ACT_REQ_RENEW;
         word0.new_transaction = 1'b0;
         word0.request_address = own_ff;
         word0.client_phase    = phase_ff;
         word0.bound_address   = own_ff;
         word0.last            = !do_restart;
      end else if (!do_restart) begin
         word0.action          = do_emit ? emit_action : ACT_NONE;
         word0.new_transaction = 1'b0;
         word0.request_address = emit_addr;
         word0.request_server  = emit_server;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_NO_LINK;
         link_ff     <= 1'b0;
         seconds_ff  <= '0;
         deadline_ff <= '0;
         backoff_ff  <= RESET_INITIAL_WAIT;
         attempts_ff <= '0;
         lease_total_ff <= '0;
         lease_left_ff  <= '0;
         offered_ff  <= '0;
         server_ff   <= '0;
         own_ff      <= '0;
         mask_ff     <= '0;
         router_ff   <= '0;
         dns_ff      <= '0;
         ntp_ff      <= '0;
      end else if (step_go) begin
         phase_ff    <= phase_in;
         link_ff     <= link_in;
         seconds_ff  <= seconds_in;
         deadline_ff <= deadline_in;
         backoff_ff  <= backoff_in;
         attempts_ff <= attempts_in;
         lease_total_ff <= lease_total_in;
         lease_left_ff  <= lease_left_in;
         offered_ff  <= offered_in;
         server_ff   <= server_in;
         own_ff      <= own_in;
         mask_ff     <= mask_in;
         router_ff   <= router_in;
         dns_ff      <= dns_in;
         ntp_ff      <= ntp_in;
      end
   end

   assign q_pop = rsp_valid && !rsp_stall;

   dhcpc_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (step_go),
      .push_two   (do_renew && do_restart),
      .push_data0 (word0),
      .push_data1 (word1),
      .room       (q_room),
      .pop        (q_pop),
      .head_valid (rsp_valid),
      .head_data  (head)
   );

   assign rsp_action          = head.action;
   assign rsp_new_transaction = head.new_transaction;
   assign rsp_request_address = head.request_address;
   assign rsp_request_server  = head.request_server;
   assign rsp_client_phase    = head.client_phase;
   assign rsp_bound_address   = head.bound_address;
   assign rsp_subnet_mask     = head.subnet_mask;
   assign rsp_router_address  = head.router_address;
   assign rsp_dns_address     = head.dns_address;
   assign rsp_time_server     = head.time_server;
   assign rsp_last            = head.last;

   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff != PH_NO_LINK) |-> link_ff)
      else $error("client left no-link phase without link");
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff != PH_BOUND) |-> (own_ff == '0))
      else $error("own address held outside bound phase");
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == PH_DISCOVER || phase_ff == PH_REQUEST) |-> (attempts_ff != '0))
      else $error("attempt count zero while soliciting");
   assert property (@(posedge clock) disable iff (reset)
                    (step_go && do_renew && do_restart) |=> (phase_ff == PH_DISCOVER))
      else $error("double word step did not restart discovery");

endmodule
